FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle, outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/euq_pkg.sv
// Shared types and constants for the Euler-to-quaternion pipeline.
// Depends on nothing; used by the CORDIC lanes, the combiner and the top level.
package euq_pkg;

  localparam int unsigned XW = 33;
  localparam int unsigned ZW = 34;
  localparam int unsigned QW = 16;
  localparam int unsigned MaxStages = 32;
  localparam int unsigned LaneExtra = 2;
  localparam int unsigned CombLatency = 3;

  localparam logic signed [XW-1:0] GainQ30 = 33'sd652032875;
  localparam logic signed [QW-1:0] Q14One = 16'sd16384;

  localparam logic signed [31:0] AtanTab [MaxStages] = '{
    32'sd1073741824, 32'sd633866812, 32'sd334917814, 32'sd170009512,
    32'sd85334662, 32'sd42708930, 32'sd21359676, 32'sd10680490,
    32'sd5340326, 32'sd2670174, 32'sd1335088, 32'sd667544,
    32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
    32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608,
    32'sd1304, 32'sd652, 32'sd326, 32'sd163,
    32'sd81, 32'sd41, 32'sd20, 32'sd10,
    32'sd5, 32'sd3, 32'sd1, 32'sd1
  };

  typedef struct packed {
    logic signed [QW-1:0] cos_q14;
    logic signed [QW-1:0] sin_q14;
  } trig_t;

  function automatic logic signed [QW-1:0] sat_q14(input logic signed [47:0] v);
    logic signed [QW-1:0] r;
    if (v > 48'sd16384) begin
      r = Q14One;
    end else if (v < -48'sd16384) begin
      r = -Q14One;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/euq_if.sv
// Valid/ready channel interfaces for angle requests and quaternion results.
// Depends on nothing.
interface euq_in_if #(
  parameter int unsigned ANGLE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface euq_out_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

FILE: rtl/euq_cordic_lane.sv
// One pipelined rotation-mode CORDIC lane: half-angle cosine and sine in Q1.14.
// Depends on euq_pkg.
module euq_cordic_lane import euq_pkg::*; #(
  parameter int unsigned ANGLE_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [ANGLE_WIDTH-1:0] angle_i,
  output trig_t                  trig_o
);

  localparam int unsigned NumStages =
    (CORDIC_STAGES < MaxStages) ? CORDIC_STAGES : MaxStages;

  logic signed [XW-1:0] x_d [NumStages+1];
  logic signed [XW-1:0] y_d [NumStages+1];
  logic signed [ZW-1:0] z_d [NumStages+1];
  logic signed [XW-1:0] x_q [NumStages+1];
  logic signed [XW-1:0] y_q [NumStages+1];
  logic signed [ZW-1:0] z_q [NumStages+1];
  logic signed [47:0]   cos_rnd;
  logic signed [47:0]   sin_rnd;
  trig_t                trig_d;
  trig_t                trig_q;

  // Load: scale the angle so that the half angle has pi at 2^32.
  always_comb begin
    x_d[0] = GainQ30;
    y_d[0] = '0;
    z_d[0] = ZW'({{(ZW-ANGLE_WIDTH){angle_i[ANGLE_WIDTH-1]}}, angle_i}) <<< (32-ANGLE_WIDTH);
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    logic signed [XW-1:0] y_sh;
    logic signed [XW-1:0] x_sh;
    logic signed [ZW-1:0] atan_v;

    assign y_sh   = y_q[i] >>> i;
    assign x_sh   = x_q[i] >>> i;
    assign atan_v = ZW'(AtanTab[i]);

    always_comb begin
      if (z_q[i][ZW-1]) begin
        x_d[i+1] = x_q[i] + y_sh;
        y_d[i+1] = y_q[i] - x_sh;
        z_d[i+1] = z_q[i] + atan_v;
      end else begin
        x_d[i+1] = x_q[i] - y_sh;
        y_d[i+1] = y_q[i] + x_sh;
        z_d[i+1] = z_q[i] - atan_v;
      end
    end
  end

  // Round to Q1.14 and saturate.
  assign cos_rnd        = (48'(x_q[NumStages]) + 48'sd32768) >>> 16;
  assign sin_rnd        = (48'(y_q[NumStages]) + 48'sd32768) >>> 16;
  assign trig_d.cos_q14 = sat_q14(cos_rnd);
  assign trig_d.sin_q14 = sat_q14(sin_rnd);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

FILE: rtl/euq_combine.sv
// Merge stage: forms the ZYX quaternion products from the three lanes' results.
// Depends on euq_pkg.
module euq_combine import euq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  trig_t                roll_i,
  input  trig_t                pitch_i,
  input  trig_t                yaw_i,
  output logic signed [QW-1:0] quat_w_o,
  output logic signed [QW-1:0] quat_x_o,
  output logic signed [QW-1:0] quat_y_o,
  output logic signed [QW-1:0] quat_z_o
);

  logic signed [31:0]   cycr_q, sysr_q, cysr_q, sycr_q;
  logic signed [QW-1:0] cp_q, sp_q;
  logic signed [47:0]   cycrcp_q, sysrsp_q, cysrcp_q, sycrsp_q;
  logic signed [47:0]   cycrsp_q, sysrcp_q, sycrcp_q, cysrsp_q;
  logic signed [47:0]   w_rnd, x_rnd, y_rnd, z_rnd;
  logic signed [QW-1:0] w_q, x_q, y_q, z_q;

  assign w_rnd = (cycrcp_q + sysrsp_q + 48'sd134217728) >>> 28;
  assign x_rnd = (cysrcp_q - sycrsp_q + 48'sd134217728) >>> 28;
  assign y_rnd = (cycrsp_q + sysrcp_q + 48'sd134217728) >>> 28;
  assign z_rnd = (sycrcp_q - cysrsp_q + 48'sd134217728) >>> 28;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cycr_q   <= 32'(yaw_i.cos_q14) * 32'(roll_i.cos_q14);
      sysr_q   <= 32'(yaw_i.sin_q14) * 32'(roll_i.sin_q14);
      cysr_q   <= 32'(yaw_i.cos_q14) * 32'(roll_i.sin_q14);
      sycr_q   <= 32'(yaw_i.sin_q14) * 32'(roll_i.cos_q14);
      cp_q     <= pitch_i.cos_q14;
      sp_q     <= pitch_i.sin_q14;
      cycrcp_q <= 48'(cycr_q) * 48'(cp_q);
      sysrsp_q <= 48'(sysr_q) * 48'(sp_q);
      cysrcp_q <= 48'(cysr_q) * 48'(cp_q);
      sycrsp_q <= 48'(sycr_q) * 48'(sp_q);
      cycrsp_q <= 48'(cycr_q) * 48'(sp_q);
      sysrcp_q <= 48'(sysr_q) * 48'(cp_q);
      sycrcp_q <= 48'(sycr_q) * 48'(cp_q);
      cysrsp_q <= 48'(cysr_q) * 48'(sp_q);
      w_q      <= sat_q14(w_rnd);
      x_q      <= sat_q14(x_rnd);
      y_q      <= sat_q14(y_rnd);
      z_q      <= sat_q14(z_rnd);
    end
  end

  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;

endmodule

FILE: rtl/euler_to_quaternion_core.sv
// Euler (roll, pitch, yaw) to quaternion converter, ZYX order, Q1.14 results.
// Depends on euq_pkg, euq_if, euq_cordic_lane, euq_combine and assert_macros.svh.
//
// Takes one angle-triple request per clock while the pipeline advances and
// returns one quaternion per request, in order. Three CORDIC lanes run side
// by side, one per angle, each with one pipeline stage per iteration (stages
// capped at 32); a three-stage multiply tree then forms the ZYX products. The
// whole pipeline advances together: it holds while a finished result waits at
// the output and the sink is not ready, so throughput is one request per cycle
// whenever results are taken as they appear.
`include "assert_macros.svh"

module euler_to_quaternion_core import euq_pkg::*; #(
  parameter int unsigned ANGLE_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  euq_in_if.sink      in_req_i,
  euq_out_if.source   out_req_o
);

  localparam int unsigned NumStages =
    (CORDIC_STAGES < MaxStages) ? CORDIC_STAGES : MaxStages;
  localparam int unsigned Depth = NumStages + LaneExtra + CombLatency;

  logic             advance;
  logic [Depth-1:0] vld_d;
  logic [Depth-1:0] vld_q;
  trig_t            trig_roll;
  trig_t            trig_pitch;
  trig_t            trig_yaw;

  assign advance = !vld_q[Depth-1] || out_req_o.ready;
  assign vld_d   = {vld_q[Depth-2:0], in_req_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= vld_d;
    end
  end

  euq_cordic_lane #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_lane_roll (
    .clk_i   (clk_i),
    .en_i    (advance),
    .angle_i (in_req_i.roll_angle),
    .trig_o  (trig_roll)
  );

  euq_cordic_lane #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_lane_pitch (
    .clk_i   (clk_i),
    .en_i    (advance),
    .angle_i (in_req_i.pitch_angle),
    .trig_o  (trig_pitch)
  );

  euq_cordic_lane #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_lane_yaw (
    .clk_i   (clk_i),
    .en_i    (advance),
    .angle_i (in_req_i.yaw_angle),
    .trig_o  (trig_yaw)
  );

  euq_combine u_combine (
    .clk_i    (clk_i),
    .en_i     (advance),
    .roll_i   (trig_roll),
    .pitch_i  (trig_pitch),
    .yaw_i    (trig_yaw),
    .quat_w_o (out_req_o.quat_w),
    .quat_x_o (out_req_o.quat_x),
    .quat_y_o (out_req_o.quat_y),
    .quat_z_o (out_req_o.quat_z)
  );

  assign in_req_i.ready  = advance;
  assign out_req_o.valid = vld_q[Depth-1];

  `ASSERT_IMP(a_wx_range, out_req_o.valid,
              (out_req_o.quat_w <= Q14One) && (out_req_o.quat_w >= -Q14One) &&
              (out_req_o.quat_x <= Q14One) && (out_req_o.quat_x >= -Q14One),
              "w or x out of range")
  `ASSERT_IMP(a_yz_range, out_req_o.valid,
              (out_req_o.quat_y <= Q14One) && (out_req_o.quat_y >= -Q14One) &&
              (out_req_o.quat_z <= Q14One) && (out_req_o.quat_z >= -Q14One),
              "y or z out of range")
  `ASSERT_IMP(a_stall_cause, !in_req_i.ready, out_req_o.valid && !out_req_o.ready,
              "input stalled without a waiting result")
  `ASSERT_RST(a_hold_valid, (out_req_o.valid && !out_req_o.ready) |=> out_req_o.valid,
              "pending result dropped")

endmodule
